@@ sv/streaming_2d_peak_finder_assert.svh @@
// ----------------------------------------------------------------------------
// Streaming 2D peak finder assertion macros
// Concurrent checks sampled on the rising clock edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef STREAMING_2D_PEAK_FINDER_ASSERT_SVH
`define STREAMING_2D_PEAK_FINDER_ASSERT_SVH

// same-cycle implication
`define S2PF_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("s2pf: same-cycle check failed");

// next-cycle implication
`define S2PF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("s2pf: next-cycle check failed");

`endif

@@ sv/s2pf_pkg.sv @@
// ----------------------------------------------------------------------------
// s2pf_pkg
// Shared widths, types and helpers of the streaming 2D peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package s2pf_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int LINE_ROWS = 3;
  localparam int PIX_W     = 32;
  localparam int ROW_W     = 12;
  localparam int COLS_W    = 11;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int NUM_W     = 22;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_RES   = 3;
  localparam int SLOT_W    = $clog2(LINE_ROWS);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_RES-1:0]             mask;
    logic [MAX_RES-1:0][ROW_W-1:0]  row;
    logic [MAX_RES-1:0][COLS_W-1:0] col;
    logic [MAX_RES-1:0][NUM_W-1:0]  num;
  } group_t;

  function automatic slot_t slot_next(input slot_t s);
    return (s == slot_t'(LINE_ROWS - 1)) ? slot_t'(0) : slot_t'(s + slot_t'(1));
  endfunction

  function automatic slot_t slot_prev(input slot_t s);
    return (s == slot_t'(0)) ? slot_t'(LINE_ROWS - 1) : slot_t'(s - slot_t'(1));
  endfunction

endpackage

`default_nettype wire

@@ sv/s2pf_out_queue.sv @@
// ----------------------------------------------------------------------------
// s2pf_out_queue
// Holds one group of up to three peak results and drains it through the
// output register, one item per cycle while out_stall is low, flagging the last of each group.
// ----------------------------------------------------------------------------
`default_nettype none
`include "streaming_2d_peak_finder_assert.svh"

module s2pf_out_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        grp_push,
  input  s2pf_pkg::group_t            grp_in,
  output logic                        grp_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [s2pf_pkg::ROW_W-1:0]  out_peak_row,
  output logic [s2pf_pkg::COLS_W-1:0] out_peak_col,
  output logic [s2pf_pkg::NUM_W-1:0]  out_peak_number,
  output logic                        out_last_of_run
);

  s2pf_pkg::group_t                  g_r;
  logic                              out_valid_r;
  logic [s2pf_pkg::ROW_W-1:0]        out_row_r;
  logic [s2pf_pkg::COLS_W-1:0]       out_col_r;
  logic [s2pf_pkg::NUM_W-1:0]        out_num_r;
  logic                              out_last_r;

  logic                              out_load;
  logic [1:0]                        sel;
  logic [s2pf_pkg::MAX_RES-1:0]      rest_mask;

  always_comb begin
    out_load  = !out_valid_r || !out_stall;
    rest_mask = g_r.mask;
    if (g_r.mask[0]) begin
      sel          = 2'd0;
      rest_mask[0] = 1'b0;
    end else if (g_r.mask[1]) begin
      sel          = 2'd1;
      rest_mask[1] = 1'b0;
    end else begin
      sel          = 2'd2;
      rest_mask[2] = 1'b0;
    end
    grp_ready = (g_r.mask == '0) || (out_load && (rest_mask == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r.mask    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (grp_push) begin
        g_r <= grp_in;
      end else if (out_load) begin
        g_r.mask <= rest_mask;
      end
      if (out_load) begin
        out_valid_r <= (g_r.mask != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && (g_r.mask != '0)) begin
      out_row_r  <= g_r.row[sel];
      out_col_r  <= g_r.col[sel];
      out_num_r  <= g_r.num[sel];
      out_last_r <= (rest_mask == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_peak_row    = out_row_r;
  assign out_peak_col    = out_col_r;
  assign out_peak_number = out_num_r;
  assign out_last_of_run = out_last_r;

  `S2PF_ASSERT_IMPL(a_more_pending, clk, rst_n, out_valid_r && !out_last_r, g_r.mask != '0)
  `S2PF_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid_r && !out_stall && !out_last_r, out_valid_r)
  `S2PF_ASSERT_IMPL(a_push_ready, clk, rst_n, grp_push, grp_ready && (grp_in.mask != '0))

endmodule

`default_nettype wire

@@ sv/streaming_2d_peak_finder.sv @@
// ----------------------------------------------------------------------------
// streaming_2d_peak_finder
// Four-neighbour peak detection over a signed matrix streamed in raster order.
//
// Input channel (in_valid / in_stall / in_pixel_value): one matrix element per
// item, row by row. Result channel (out_valid / out_stall / out_peak_*): one
// peak per item with 1-based row, column and running peak number;
// out_last_of_run marks the final result caused by one input item.
// Configuration: cfg_write_en with cfg_index 0 (rows) or 1 (columns) and
// cfg_data; any write restarts the frame. Write only while the block is idle.
// Path: an accepted item passes the decision stage, the result group and the
// output register before its first result is valid. Throughput: one item per cycle
// while each item causes at most one result and the receiver does not stall; an
// item causing k results holds the input channel while the single output register
// drains its result group. The line store takes one write and one full-column read per item.
// Reset: rows = columns = 1, frame counters cleared; the line store is not
// cleared, since every entry is written in a frame before it is read.
// When the receiver stalls, the output holds and, once the result group and
// decision stage are full, in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
`include "streaming_2d_peak_finder_assert.svh"

module streaming_2d_peak_finder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [s2pf_pkg::PIX_W-1:0] in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [s2pf_pkg::ROW_W-1:0]     out_peak_row,
  output logic [s2pf_pkg::COLS_W-1:0]    out_peak_col,
  output logic [s2pf_pkg::NUM_W-1:0]     out_peak_number,
  output logic                           out_last_of_run,
  input  logic                           cfg_write_en,
  input  logic [s2pf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [s2pf_pkg::CFG_W-1:0]     cfg_data
);

  typedef logic [s2pf_pkg::LINE_ROWS-1:0][s2pf_pkg::PIX_W-1:0] column_t;

  // configuration and frame position
  logic [s2pf_pkg::ROW_W-1:0]  rows_r;
  logic [s2pf_pkg::COLS_W-1:0] cols_r;
  logic [s2pf_pkg::ROW_W-1:0]  row_r;
  logic [s2pf_pkg::COL_W-1:0]  col_r;
  s2pf_pkg::slot_t             slot_r;

  logic                        accept;
  logic [s2pf_pkg::COLS_W-1:0] col_inc;
  logic                        col_last;
  logic                        row_last;
  logic [s2pf_pkg::COL_W-1:0]  col_nxt;
  logic [s2pf_pkg::COLS_W-1:0] cfg_cols;
  logic [s2pf_pkg::ROW_W-1:0]  cfg_rows;
  logic [s2pf_pkg::PIX_W-1:0]  pix_key;

  // line store
  column_t                     mem [s2pf_pkg::MAX_COLS];
  column_t                     rd_raw_r;
  logic                        fwd_hit_r;
  column_t                     rd_fix;

  // decision stage
  logic                        s1_v_r;
  logic [s2pf_pkg::PIX_W-1:0]  s1_pix_r;
  logic [s2pf_pkg::ROW_W-1:0]  s1_row_r;
  logic [s2pf_pkg::COL_W-1:0]  s1_col_r;
  s2pf_pkg::slot_t             s1_slot_r;
  logic                        s1_r_gt0_r;
  logic                        s1_r_gt1_r;
  logic                        s1_last_row_r;
  logic                        s1_c_gt0_r;
  logic                        s1_c_gt1_r;
  logic                        s1_c_last_r;

  column_t                     w1_r;
  column_t                     w2_r;
  logic [s2pf_pkg::PIX_W-1:0]  cur1_r;
  logic [s2pf_pkg::PIX_W-1:0]  cur2_r;
  logic [s2pf_pkg::NUM_W-1:0]  pc_r;
  logic [s2pf_pkg::NUM_W-1:0]  pc_nxt;

  s2pf_pkg::slot_t             la;
  s2pf_pkg::slot_t             lb;
  logic [s2pf_pkg::PIX_W-1:0]  va;
  logic                        d1;
  logic                        d2;
  logic                        d3;
  logic                        s1_adv;
  logic                        grp_push;
  logic                        grp_ready;
  s2pf_pkg::group_t            grp;
  logic [s2pf_pkg::NUM_W-1:0]  inc1;
  logic [s2pf_pkg::NUM_W-1:0]  inc2;
  logic [s2pf_pkg::NUM_W-1:0]  inc3;

  assign pix_key  = {~in_pixel_value[s2pf_pkg::PIX_W-1], in_pixel_value[s2pf_pkg::PIX_W-2:0]};
  assign accept   = in_valid && !in_stall;
  assign col_inc  = {1'b0, col_r} + s2pf_pkg::COLS_W'(1);
  assign col_last = (col_inc == cols_r);
  assign row_last = ((row_r + s2pf_pkg::ROW_W'(1)) == rows_r);
  assign col_nxt  = col_last ? '0 : col_inc[s2pf_pkg::COL_W-1:0];

  always_comb begin
    cfg_rows = (cfg_data == '0) ? s2pf_pkg::ROW_W'(1) : cfg_data[s2pf_pkg::ROW_W-1:0];
    cfg_cols = cfg_data[s2pf_pkg::COLS_W-1:0];
    if (cfg_cols == '0) begin
      cfg_cols = s2pf_pkg::COLS_W'(1);
    end else if (cfg_cols > s2pf_pkg::COLS_W'(s2pf_pkg::MAX_COLS)) begin
      cfg_cols = s2pf_pkg::COLS_W'(s2pf_pkg::MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= s2pf_pkg::ROW_W'(1);
      cols_r <= s2pf_pkg::COLS_W'(1);
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cfg_write_en) begin
      case (s2pf_pkg::cfg_reg_t'(cfg_index))
        s2pf_pkg::REG_NUM_ROWS: rows_r <= cfg_rows;
        s2pf_pkg::REG_NUM_COLS: cols_r <= cfg_cols;
        default: ;
      endcase
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      if (col_last) begin
        row_r  <= row_last ? '0 : row_r + s2pf_pkg::ROW_W'(1);
        slot_r <= row_last ? '0 : s2pf_pkg::slot_next(slot_r);
      end
    end
  end

  // write the item, read the next column of all rows
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[col_r][slot_r] <= pix_key;
      rd_raw_r           <= mem[col_nxt];
    end
  end

  always_comb begin
    rd_fix = rd_raw_r;
    if (fwd_hit_r) begin
      rd_fix[s1_slot_r] = s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_hit_r     <= (col_nxt == col_r);
      s1_pix_r      <= pix_key;
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_slot_r     <= slot_r;
      s1_r_gt0_r    <= (row_r != '0);
      s1_r_gt1_r    <= (row_r > s2pf_pkg::ROW_W'(1));
      s1_last_row_r <= row_last;
      s1_c_gt0_r    <= (col_r != '0);
      s1_c_gt1_r    <= (col_r > s2pf_pkg::COL_W'(1));
      s1_c_last_r   <= col_last;
    end
  end

  // decide the element above, and in the last row the element to the left
  // and the final element itself
  always_comb begin
    la = s2pf_pkg::slot_prev(s1_slot_r);
    lb = s2pf_pkg::slot_prev(la);
    va = w1_r[la];
    d1 = s1_r_gt0_r
      && (!s1_r_gt1_r || (va >= w1_r[lb]))
      && (va >= s1_pix_r)
      && (!s1_c_gt0_r || (va >= w2_r[la]))
      && (s1_c_last_r || (va >= rd_fix[la]));
    d2 = s1_last_row_r && s1_c_gt0_r
      && (!s1_r_gt0_r || (cur1_r >= w2_r[la]))
      && (!s1_c_gt1_r || (cur1_r >= cur2_r))
      && (cur1_r >= s1_pix_r);
    d3 = s1_last_row_r && s1_c_last_r
      && (!s1_r_gt0_r || (s1_pix_r >= w1_r[la]))
      && (!s1_c_gt0_r || (s1_pix_r >= cur1_r));

    inc1 = {{(s2pf_pkg::NUM_W-1){1'b0}}, d1};
    inc2 = {{(s2pf_pkg::NUM_W-1){1'b0}}, d2};
    inc3 = {{(s2pf_pkg::NUM_W-1){1'b0}}, d3};

    grp.mask   = {d3, d2, d1};
    grp.row[0] = s1_row_r;
    grp.row[1] = s1_row_r + s2pf_pkg::ROW_W'(1);
    grp.row[2] = s1_row_r + s2pf_pkg::ROW_W'(1);
    grp.col[0] = {1'b0, s1_col_r} + s2pf_pkg::COLS_W'(1);
    grp.col[1] = {1'b0, s1_col_r};
    grp.col[2] = {1'b0, s1_col_r} + s2pf_pkg::COLS_W'(1);
    grp.num[0] = pc_r + s2pf_pkg::NUM_W'(1);
    grp.num[1] = pc_r + inc1 + s2pf_pkg::NUM_W'(1);
    grp.num[2] = pc_r + inc1 + inc2 + s2pf_pkg::NUM_W'(1);

    pc_nxt   = (s1_last_row_r && s1_c_last_r) ? '0 : pc_r + inc1 + inc2 + inc3;
    s1_adv   = s1_v_r && ((grp.mask == '0) || grp_ready);
    grp_push = s1_v_r && (grp.mask != '0) && grp_ready;
    in_stall = s1_v_r && !s1_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (cfg_write_en) begin
      pc_r <= '0;
    end else if (s1_adv) begin
      pc_r <= pc_nxt;
    end
  end

  // advance the column window and the current-row history
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      w1_r   <= rd_fix;
      w2_r   <= w1_r;
      cur1_r <= s1_pix_r;
      cur2_r <= cur1_r;
    end
  end

  s2pf_out_queue u_out_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .grp_push        (grp_push),
    .grp_in          (grp),
    .grp_ready       (grp_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_peak_number (out_peak_number),
    .out_last_of_run (out_last_of_run)
  );

  `S2PF_ASSERT_IMPL(a_col_range, clk, rst_n, 1'b1, {1'b0, col_r} < cols_r)
  `S2PF_ASSERT_IMPL(a_row_range, clk, rst_n, 1'b1, row_r < rows_r)
  `S2PF_ASSERT_IMPL(a_fwd_single_col, clk, rst_n, accept && (col_nxt == col_r), cols_r == s2pf_pkg::COLS_W'(1))

endmodule

`default_nettype wire

@@ test/streaming_2d_peak_finder_tb.sv @@
// ----------------------------------------------------------------------------
// streaming_2d_peak_finder_tb
// Streams signed matrices through the peak finder under random input gaps and
// output stalls. A scoreboard keeps its own line store and frame counters,
// predicts every four-neighbour peak with row, column, running number and
// last-of-run flag, and checks each result in order. Frame shapes are
// reprogrammed between phases, including zero, saturating and widest sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module streaming_2d_peak_finder_tb;

  typedef struct {
    logic [s2pf_pkg::ROW_W-1:0]  row;
    logic [s2pf_pkg::COLS_W-1:0] col;
    logic [s2pf_pkg::NUM_W-1:0]  num;
    logic                        last_flag;
  } peak_t;

  class peak_scoreboard;
    logic signed [s2pf_pkg::PIX_W-1:0] lines [s2pf_pkg::LINE_ROWS][s2pf_pkg::MAX_COLS];
    logic [s2pf_pkg::ROW_W-1:0]  rows_reg;
    logic [s2pf_pkg::COLS_W-1:0] cols_reg;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [22:0]       found;
    peak_t             batch[$];
    peak_t             pending[$];
    int                errors;

    function void restart();
      row_pos = 0;
      col_pos = 0;
      found   = '0;
    endfunction

    function void reset_state();
      rows_reg = 1;
      cols_reg = 1;
      errors   = 0;
      restart();
    endfunction

    function void set_reg(s2pf_pkg::cfg_reg_t idx, logic [s2pf_pkg::CFG_W-1:0] data);
      if (idx == s2pf_pkg::REG_NUM_ROWS) begin
        rows_reg = data[s2pf_pkg::ROW_W-1:0];
      end else begin
        cols_reg = data[s2pf_pkg::COLS_W-1:0];
      end
      restart();
    endfunction

    function int unsigned rows_used();
      return (rows_reg == 0) ? 1 : rows_reg;
    endfunction

    function int unsigned cols_used();
      if (cols_reg == 0) return 1;
      if (cols_reg > s2pf_pkg::MAX_COLS) return s2pf_pkg::MAX_COLS;
      return cols_reg;
    endfunction

    function bit is_peak(int unsigned r, int unsigned k, int unsigned rows, int unsigned cols);
      logic signed [s2pf_pkg::PIX_W-1:0] v;
      bit ok;
      v  = lines[r % s2pf_pkg::LINE_ROWS][k];
      ok = 1'b1;
      if (r > 0 && v < lines[(r - 1) % s2pf_pkg::LINE_ROWS][k]) ok = 1'b0;
      if (r + 1 < rows && v < lines[(r + 1) % s2pf_pkg::LINE_ROWS][k]) ok = 1'b0;
      if (k > 0 && v < lines[r % s2pf_pkg::LINE_ROWS][k - 1]) ok = 1'b0;
      if (k + 1 < cols && v < lines[r % s2pf_pkg::LINE_ROWS][k + 1]) ok = 1'b0;
      return ok;
    endfunction

    function void take(int unsigned r, int unsigned k);
      peak_t p;
      found       = found + 1'b1;
      p.row       = s2pf_pkg::ROW_W'(r + 1);
      p.col       = s2pf_pkg::COLS_W'(k + 1);
      p.num       = found[s2pf_pkg::NUM_W-1:0];
      p.last_flag = 1'b0;
      batch.push_back(p);
    endfunction

    function void note_pixel(logic signed [s2pf_pkg::PIX_W-1:0] v);
      int unsigned rows;
      int unsigned cols;
      rows = rows_used();
      cols = cols_used();
      if (row_pos >= rows || col_pos >= cols) restart();
      lines[row_pos % s2pf_pkg::LINE_ROWS][col_pos] = v;
      batch.delete();
      if (row_pos > 0 && is_peak(row_pos - 1, col_pos, rows, cols)) take(row_pos - 1, col_pos);
      if (row_pos + 1 == rows) begin
        if (col_pos > 0 && is_peak(row_pos, col_pos - 1, rows, cols))
          take(row_pos, col_pos - 1);
        if (col_pos + 1 == cols && is_peak(row_pos, col_pos, rows, cols))
          take(row_pos, col_pos);
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_flag = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
      col_pos++;
      if (col_pos >= cols) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= rows) begin
          row_pos = 0;
          found   = '0;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_peak(logic [s2pf_pkg::ROW_W-1:0] r, logic [s2pf_pkg::COLS_W-1:0] c,
                    logic [s2pf_pkg::NUM_W-1:0] n, logic l);
      peak_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected peak at row %0d col %0d number %0d", r, c, n));
        return;
      end
      want = pending.pop_front();
      if (r !== want.row)
        report($sformatf("peak_row got %0d, want %0d", r, want.row));
      if (c !== want.col)
        report($sformatf("peak_col got %0d, want %0d (row %0d)", c, want.col, want.row));
      if (n !== want.num)
        report($sformatf("peak_number got %0d, want %0d (row %0d col %0d)",
                         n, want.num, want.row, want.col));
      if (l !== want.last_flag)
        report($sformatf("last_of_run got %b, want %b (row %0d col %0d)",
                         l, want.last_flag, want.row, want.col));
    endtask

    task leftovers();
      if (pending.size() != 0)
        report($sformatf("%0d expected peaks never arrived", pending.size()));
    endtask
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [s2pf_pkg::PIX_W-1:0] in_pixel_value;
  logic                              out_valid;
  logic                              out_stall;
  logic [s2pf_pkg::ROW_W-1:0]        out_peak_row;
  logic [s2pf_pkg::COLS_W-1:0]       out_peak_col;
  logic [s2pf_pkg::NUM_W-1:0]        out_peak_number;
  logic                              out_last_of_run;
  logic                              cfg_write_en;
  logic [s2pf_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [s2pf_pkg::CFG_W-1:0]        cfg_data;

  peak_scoreboard peaks;
  int             stall_mode;
  int             stall_left;
  int unsigned    stall_tick;

  streaming_2d_peak_finder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_peak_number (out_peak_number),
    .out_last_of_run (out_last_of_run),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((stall_tick % 7) < 3);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      peaks.check_peak(out_peak_row, out_peak_col, out_peak_number, out_last_of_run);
  end

  function automatic logic signed [s2pf_pkg::PIX_W-1:0] pick_pixel(int spread);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {1'b1, {(s2pf_pkg::PIX_W-1){1'b0}}};
    if (sel == 1) return {1'b0, {(s2pf_pkg::PIX_W-1){1'b1}}};
    if (sel < 3 + 4 * spread) return s2pf_pkg::PIX_W'($signed($urandom_range(0, 6)) - 3);
    return $urandom;
  endfunction

  task automatic drive_pixel(logic signed [s2pf_pkg::PIX_W-1:0] v);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_pixel_value <= v;
    do @(posedge clk); while (in_stall);
    peaks.note_pixel(v);
  endtask

  task automatic pause_input(int n);
    repeat (n) @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    pause_input(1);
    while (peaks.pending.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(s2pf_pkg::cfg_reg_t idx, logic [s2pf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    peaks.set_reg(idx, data);
    @(negedge clk) cfg_write_en <= 1'b0;
  endtask

  task automatic configure(logic [s2pf_pkg::CFG_W-1:0] rows,
                           logic [s2pf_pkg::CFG_W-1:0] cols);
    settle();
    write_reg(s2pf_pkg::REG_NUM_ROWS, rows);
    write_reg(s2pf_pkg::REG_NUM_COLS, cols);
  endtask

  task automatic send_stream(int count, int spread, bit gaps, int drain_at);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) drain_results();
      if (gaps && burst == 0) begin
        pause_input($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
      drive_pixel(pick_pixel(spread));
      burst--;
    end
  endtask

  localparam logic signed [s2pf_pkg::PIX_W-1:0] PIX_MIN = {1'b1, {(s2pf_pkg::PIX_W-1){1'b0}}};
  localparam logic signed [s2pf_pkg::PIX_W-1:0] PIX_MAX = {1'b0, {(s2pf_pkg::PIX_W-1){1'b1}}};

  initial begin
    logic signed [s2pf_pkg::PIX_W-1:0] grid [12];
    int sent;
    int rows;
    int cols;
    int count;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_value = '0;
    out_stall      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_index      = s2pf_pkg::REG_NUM_ROWS;
    cfg_data       = '0;
    stall_mode     = 0;
    stall_left     = 0;
    stall_tick     = 0;
    peaks          = new();
    peaks.reset_state();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // single element frames straight out of reset
    drive_pixel(PIX_MIN);
    drive_pixel(PIX_MAX);

    grid = '{PIX_MAX, PIX_MIN, 0, -1,
             PIX_MIN, PIX_MAX, PIX_MAX, -1,
             5, 5, 5, PIX_MIN};
    configure(3, 4);
    foreach (grid[i]) drive_pixel(grid[i]);
    repeat (4) drive_pixel(-1);

    configure(0, 0);
    drive_pixel(7);
    drive_pixel(-7);

    configure(2, 1);
    drive_pixel(PIX_MIN);
    drive_pixel(PIX_MIN);
    drive_pixel(PIX_MAX);

    sent = 0;
    while (sent < 190) begin
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) begin
        rows = $urandom_range(2, 3);
        cols = $urandom_range(9, 64);
      end
      if ($urandom_range(0, 4) == 0) begin
        settle();
        write_reg(s2pf_pkg::REG_NUM_COLS, s2pf_pkg::CFG_W'(cols));
        rows = peaks.rows_used();
      end else begin
        configure(s2pf_pkg::CFG_W'(rows), s2pf_pkg::CFG_W'(cols));
      end
      count = rows * cols * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, rows * cols);
      if (count > 60) count = 60;
      if (count > 190 - sent) count = 190 - sent;
      send_stream(count, $urandom_range(0, 1), $urandom_range(0, 3) != 0,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1);
      sent += count;
    end

    configure(4095, 3);
    send_stream(30, 1, 1'b1, 15);

    // column count saturates to the line store width
    configure(1, 12'hFFF);
    send_stream(24, 0, 1'b1, -1);

    settle();
    peaks.leftovers();
    if (peaks.errors == 0) begin
      $display("streaming_2d_peak_finder: match");
    end else begin
      $display("streaming_2d_peak_finder: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("streaming_2d_peak_finder: mismatch");
    $finish;
  end

endmodule
